FILE: rtl/y2r_pkg.sv
// Shared types, constants and helper functions for the YUV 4:2:0 to RGB converter.
// Used by the converter top level, the chroma store and the port checker.
`default_nettype none

package y2r_pkg;

    // Field and datapath widths.
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 8;
    localparam int IDX_W     = 32;
    localparam int SUM_W     = 27;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LUMA_WIDTH    = 2'd0,
        REG_LUMA_HEIGHT   = 2'd1,
        REG_CHROMA_WIDTH  = 2'd2,
        REG_CHROMA_HEIGHT = 2'd3
    } t_cfg_reg;

    // Reset values of the configuration registers.
    localparam logic [CFG_W-1:0] RST_LUMA_WIDTH    = 12'd128;
    localparam logic [CFG_W-1:0] RST_LUMA_HEIGHT   = 12'd96;
    localparam logic [CFG_W-1:0] RST_CHROMA_WIDTH  = 12'd64;
    localparam logic [CFG_W-1:0] RST_CHROMA_HEIGHT = 12'd48;

    // Input operation codes.
    localparam logic OP_CHROMA = 1'b0;
    localparam logic OP_LUMA   = 1'b1;

    // BT.601 full-range coefficients in Q16.
    localparam logic signed [18:0] COEF_RV = 19'sd91881;
    localparam logic signed [18:0] COEF_GU = 19'sd22553;
    localparam logic signed [18:0] COEF_GV = 19'sd46802;
    localparam logic signed [18:0] COEF_BU = 19'sd116130;

    // Largest Q16 sum that does not saturate (255.0 in Q16).
    localparam logic signed [SUM_W-1:0] SAT_Q16 = 27'sd16711680;

    // Pixel sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INDEX,
        ST_ADDR,
        ST_READ,
        ST_OUT
    } t_state;

    // Input item.
    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_u;
        logic [PIX_W-1:0] chroma_v;
    } t_in_item;

    // Result item.
    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             last;
    } t_out_item;

    // One entry of the chroma store.
    typedef struct packed {
        logic [PIX_W-1:0] u;
        logic [PIX_W-1:0] v;
    } t_chroma_pair;

    // Clamp a Q16 sum to 0..255 and drop the fraction.
    function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] res;
        res = s[23:16];
        if (s < 0) begin
            res = '0;
        end else if (s > SAT_Q16) begin
            res = '1;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/y2r_chroma_store.sv
// Chroma store: one synchronous memory holding a U and V sample per entry.
// Uses y2r_pkg for the entry type; one write port and one registered read port.
`default_nettype none

module y2r_chroma_store #(
    parameter int DEPTH = 4096
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire y2r_pkg::t_chroma_pair      i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output y2r_pkg::t_chroma_pair           o_rd_data
);

    y2r_pkg::t_chroma_pair r_mem [DEPTH];
    y2r_pkg::t_chroma_pair r_rd_data;

    // Write port. The sequencer never writes and reads in the same item,
    // so no forwarding path is needed.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

FILE: rtl/y2r_divider.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
// Stand-alone; used by the converter top level for the chroma coordinates.
`default_nettype none

module y2r_divider #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 12
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_busy,
    output logic [NUM_W-1:0]      o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   w_trial;
    logic             w_bit;
    logic [DEN_W-1:0] w_rem;

    // One restoring step: shift in the next numerator bit and try a subtract.
    always_comb begin
        w_trial = {r_rem, r_quo[NUM_W-1]};
        w_bit   = (w_trial >= {1'b0, r_den});
        if (w_bit) begin
            w_rem = DEN_W'(w_trial - {1'b0, r_den});
        end else begin
            w_rem = w_trial[DEN_W-1:0];
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(NUM_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Numerator shifts out as quotient bits shift in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[NUM_W-2:0], w_bit};
            r_rem <= w_rem;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

FILE: rtl/yuv420_to_rgb_converter.sv
// YUV 4:2:0 to RGB888 converter (BT.601 full range), top level.
// Depends on y2r_pkg, y2r_chroma_store and y2r_divider.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): a frame is sent as
//   chroma pairs (op = load chroma) in raster order, then luma pixels in
//   raster order. Each luma pixel gives one RGB transfer on the output
//   channel (o_out_valid / i_out_stall / o_out_data); a chroma load gives none.
//   The last flag marks the final pixel of a frame; then the column, row and
//   chroma load counters return to zero.
//   Configuration (i_cfg_wr_en / i_cfg_index / i_cfg_data) sets the luma and
//   chroma dimensions; write it only while no pixel is in flight.
// Sequencing:
//   A chroma load is taken in the idle state, which it does not leave. A luma
//   pixel passes the states ST_DIV, ST_INDEX, ST_ADDR, ST_READ and ST_OUT;
//   in ST_DIV the bit-serial divider scales the column and row into chroma
//   coordinates. The input stalls until the result enters the output register.
// Reset: synchronous, active low; clears counters and the output valid flag,
//   resets the configuration to defaults. Chroma store contents are not cleared.
// Stall: the output register holds a result while the receiver stalls; the
//   next item is still taken and its result waits in the final state.
`default_nettype none

module yuv420_to_rgb_converter #(
    parameter int CHROMA_DEPTH = 4096,
    parameter int MAX_DIM      = 2048
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire y2r_pkg::t_in_item                    i_in_data,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output y2r_pkg::t_out_item                        o_out_data,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [y2r_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [y2r_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int CFG_W  = y2r_pkg::CFG_W;
    localparam int IDX_W  = y2r_pkg::IDX_W;
    localparam int SUM_W  = y2r_pkg::SUM_W;
    localparam int PIX_W  = y2r_pkg::PIX_W;
    localparam int CNT_W  = $clog2(MAX_DIM);
    localparam int NUM_W  = CNT_W + CFG_W;
    localparam int ADDR_W = $clog2(CHROMA_DEPTH);
    localparam int LDX_W  = $clog2(CHROMA_DEPTH + 1);

    // Dimension as used: zero counts as one, large values saturate.
    function automatic logic [CFG_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
        logic [CFG_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = CFG_W'(1);
        end else if (32'(v) > 32'(MAX_DIM)) begin
            res = CFG_W'(MAX_DIM);
        end
        return res;
    endfunction

    y2r_pkg::t_state    r_state, n_state;
    logic [CFG_W-1:0]   r_luma_width, r_luma_height, r_chroma_width, r_chroma_height;
    logic [CNT_W-1:0]   r_column, n_column;
    logic [CNT_W-1:0]   r_row, n_row;
    logic [LDX_W-1:0]   r_load_idx, n_load_idx;
    logic [PIX_W-1:0]   r_luma, n_luma;
    logic               r_last, n_last;
    logic [IDX_W-1:0]   r_prod, n_prod;
    logic               r_in_range, n_in_range;
    logic signed [SUM_W-1:0] r_sum_r, r_sum_g, r_sum_b;
    logic signed [SUM_W-1:0] n_sum_r, n_sum_g, n_sum_b;
    logic               r_out_valid, n_out_valid;
    y2r_pkg::t_out_item r_out_data, n_out_data;

    logic [CFG_W-1:0]   w_yw, w_yh, w_cw, w_ch;
    logic               w_in_xfer, w_out_xfer;
    logic               w_row_end, w_frame_end;
    logic [NUM_W-1:0]   w_num_x, w_num_y;
    logic               w_div_start;
    logic               w_busy_x, w_busy_y;
    logic [NUM_W-1:0]   w_quo_x, w_quo_y;
    logic [NUM_W+CFG_W-1:0] w_prod_full;
    logic [IDX_W-1:0]   w_idx;
    logic               w_wr_en, w_rd_en;
    y2r_pkg::t_chroma_pair w_wr_data, w_rd_data;
    logic [PIX_W-1:0]   w_u, w_v;
    logic signed [9:0]  w_d, w_e;
    logic signed [SUM_W-1:0] w_y_q16;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_luma_width    <= y2r_pkg::RST_LUMA_WIDTH;
            r_luma_height   <= y2r_pkg::RST_LUMA_HEIGHT;
            r_chroma_width  <= y2r_pkg::RST_CHROMA_WIDTH;
            r_chroma_height <= y2r_pkg::RST_CHROMA_HEIGHT;
        end else if (i_cfg_wr_en) begin
            unique case (y2r_pkg::t_cfg_reg'(i_cfg_index))
                y2r_pkg::REG_LUMA_WIDTH:    r_luma_width    <= i_cfg_data;
                y2r_pkg::REG_LUMA_HEIGHT:   r_luma_height   <= i_cfg_data;
                y2r_pkg::REG_CHROMA_WIDTH:  r_chroma_width  <= i_cfg_data;
                y2r_pkg::REG_CHROMA_HEIGHT: r_chroma_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_yw = eff_dim(r_luma_width);
    assign w_yh = eff_dim(r_luma_height);
    assign w_cw = eff_dim(r_chroma_width);
    assign w_ch = eff_dim(r_chroma_height);

    assign o_in_stall = (r_state != y2r_pkg::ST_IDLE);
    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_xfer = r_out_valid && !i_out_stall;

    // Raster position tests for the pixel being taken.
    assign w_row_end   = (32'(r_column) + 32'd1) >= 32'(w_yw);
    assign w_frame_end = w_row_end && ((32'(r_row) + 32'd1) >= 32'(w_yh));

    // Scaled coordinates: cx = column * cw / yw, cy = row * ch / yh.
    assign w_num_x     = NUM_W'(r_column) * NUM_W'(w_cw);
    assign w_num_y     = NUM_W'(r_row) * NUM_W'(w_ch);
    assign w_div_start = w_in_xfer && (i_in_data.op == y2r_pkg::OP_LUMA);

    y2r_divider #(
        .NUM_W (NUM_W),
        .DEN_W (CFG_W)
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_x),
        .i_den   (w_yw),
        .o_busy  (w_busy_x),
        .o_quo   (w_quo_x)
    );

    y2r_divider #(
        .NUM_W (NUM_W),
        .DEN_W (CFG_W)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num_y),
        .i_den   (w_yh),
        .o_busy  (w_busy_y),
        .o_quo   (w_quo_y)
    );

    // Store index: cy * cw + cx, kept modulo 2^32.
    assign w_prod_full = (NUM_W+CFG_W)'(w_quo_y) * (NUM_W+CFG_W)'(w_cw);
    assign w_idx       = r_prod + IDX_W'(w_quo_x);

    // Chroma store access.
    assign w_wr_en   = w_in_xfer && (i_in_data.op == y2r_pkg::OP_CHROMA)
                       && (r_load_idx < LDX_W'(CHROMA_DEPTH));
    assign w_wr_data = '{u: i_in_data.chroma_u, v: i_in_data.chroma_v};
    assign w_rd_en   = (r_state == y2r_pkg::ST_ADDR);

    y2r_chroma_store #(
        .DEPTH (CHROMA_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_load_idx[ADDR_W-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_idx[ADDR_W-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Chroma outside the store reads as U = V = 0.
    assign w_u     = r_in_range ? w_rd_data.u : '0;
    assign w_v     = r_in_range ? w_rd_data.v : '0;
    assign w_d     = $signed({2'b00, w_u}) - 10'sd128;
    assign w_e     = $signed({2'b00, w_v}) - 10'sd128;
    assign w_y_q16 = SUM_W'($signed({1'b0, r_luma, 16'h0000}));

    // Sequencer: next state, counters and datapath loads.
    always_comb begin
        n_state     = r_state;
        n_column    = r_column;
        n_row       = r_row;
        n_load_idx  = r_load_idx;
        n_luma      = r_luma;
        n_last      = r_last;
        n_prod      = r_prod;
        n_in_range  = r_in_range;
        n_sum_r     = r_sum_r;
        n_sum_g     = r_sum_g;
        n_sum_b     = r_sum_b;
        n_out_valid = r_out_valid && !w_out_xfer;
        n_out_data  = r_out_data;

        unique case (r_state)
            y2r_pkg::ST_IDLE: begin
                if (w_in_xfer) begin
                    if (i_in_data.op == y2r_pkg::OP_LUMA) begin
                        n_luma  = i_in_data.luma;
                        n_last  = w_frame_end;
                        n_state = y2r_pkg::ST_DIV;
                        if (w_frame_end) begin
                            n_column   = '0;
                            n_row      = '0;
                            n_load_idx = '0;
                        end else if (w_row_end) begin
                            n_column = '0;
                            n_row    = CNT_W'(r_row + CNT_W'(1));
                        end else begin
                            n_column = CNT_W'(r_column + CNT_W'(1));
                        end
                    end else if (w_wr_en) begin
                        n_load_idx = LDX_W'(r_load_idx + LDX_W'(1));
                    end
                end
            end
            y2r_pkg::ST_DIV: begin
                if (!w_busy_x && !w_busy_y) begin
                    n_state = y2r_pkg::ST_INDEX;
                end
            end
            y2r_pkg::ST_INDEX: begin
                n_prod  = IDX_W'(w_prod_full);
                n_state = y2r_pkg::ST_ADDR;
            end
            y2r_pkg::ST_ADDR: begin
                n_in_range = (w_idx < IDX_W'(CHROMA_DEPTH));
                n_state    = y2r_pkg::ST_READ;
            end
            y2r_pkg::ST_READ: begin
                n_sum_r = w_y_q16 + SUM_W'(y2r_pkg::COEF_RV) * SUM_W'(w_e);
                n_sum_g = w_y_q16 - SUM_W'(y2r_pkg::COEF_GU) * SUM_W'(w_d)
                                  - SUM_W'(y2r_pkg::COEF_GV) * SUM_W'(w_e);
                n_sum_b = w_y_q16 + SUM_W'(y2r_pkg::COEF_BU) * SUM_W'(w_d);
                n_state = y2r_pkg::ST_OUT;
            end
            y2r_pkg::ST_OUT: begin
                if (!r_out_valid || w_out_xfer) begin
                    n_out_data.red   = y2r_pkg::clamp_q16(r_sum_r);
                    n_out_data.green = y2r_pkg::clamp_q16(r_sum_g);
                    n_out_data.blue  = y2r_pkg::clamp_q16(r_sum_b);
                    n_out_data.last  = r_last;
                    n_out_valid      = 1'b1;
                    n_state          = y2r_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = y2r_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= y2r_pkg::ST_IDLE;
            r_column    <= '0;
            r_row       <= '0;
            r_load_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_column    <= n_column;
            r_row       <= n_row;
            r_load_idx  <= n_load_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_luma     <= n_luma;
        r_last     <= n_last;
        r_prod     <= n_prod;
        r_in_range <= n_in_range;
        r_sum_r    <= n_sum_r;
        r_sum_g    <= n_sum_g;
        r_sum_b    <= n_sum_b;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

FILE: rtl/y2r_checker.sv
// Port-level checker for the YUV to RGB converter, bound to the top level.
// Uses y2r_pkg for the item types and operation codes.
`default_nettype none

module y2r_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire y2r_pkg::t_in_item              i_in_data,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire y2r_pkg::t_out_item             o_out_data,
    input wire logic                           i_cfg_wr_en,
    input wire logic [y2r_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input wire logic [y2r_pkg::CFG_W-1:0]      i_cfg_data
);

    logic w_cfg_seen;
    assign w_cfg_seen = i_cfg_wr_en && (i_cfg_index == i_cfg_index) && (i_cfg_data == i_cfg_data);

    // Reset empties the output register and frees the input.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output valid or input stall after reset");

    // A stalled result stays put until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result changed");

    // A luma pixel that is taken sets the input stall while it is in flight.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall && i_in_data.op == y2r_pkg::OP_LUMA)
        |=> o_in_stall)
        else $error("input not stalled while a pixel is in flight");

    // A chroma load leaves the input free in the cycle after it when no configuration write is seen.
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && i_in_valid && !o_in_stall && i_in_data.op == y2r_pkg::OP_CHROMA
         && !w_cfg_seen) |=> !o_in_stall)
        else $error("chroma load held the input");

    // A new result only appears at the end of a pixel's processing.
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a pixel in flight");

endmodule

bind yuv420_to_rgb_converter y2r_checker u_y2r_checker (.*);

`default_nettype wire
